FILE: hw/rtl/bplms_pkg.sv
`default_nettype none

package bplms_pkg;

	localparam int unsigned HoldW   = 16;
	localparam int unsigned LimitW  = 16;
	localparam int unsigned CountW  = 4;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgW    = 16;

	localparam logic [HoldW-1:0]  HOLD_MAX = '1;

	localparam logic [LimitW-1:0] SHORT_LIMIT_RST  = 16'd10;
	localparam logic [LimitW-1:0] MEDIUM_LIMIT_RST = 16'd100;
	localparam logic [LimitW-1:0] LONG_LIMIT_RST   = 16'd500;
	localparam logic [CountW-1:0] MODE_COUNT_RST   = 4'd12;
	localparam logic [CountW-1:0] SERIES_LIMIT_RST = 4'd11;

	localparam logic [CountW-1:0] MODE_RST   = 4'd1;
	localparam logic [CountW-1:0] SERIES_RST = 4'd1;
	localparam logic [CountW-1:0] COUNT_ONE  = 4'd1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SHORT_LIMIT  = 3'd0,
		REG_MEDIUM_LIMIT = 3'd1,
		REG_LONG_LIMIT   = 3'd2,
		REG_MODE_COUNT   = 3'd3,
		REG_SERIES_LIMIT = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SHORT  = 2'd1,
		KIND_MEDIUM = 2'd2,
		KIND_LONG   = 2'd3
	} press_kind_t;

endpackage

`default_nettype wire

FILE: hw/rtl/button_press_length_mode_selector_core.sv
`default_nettype none

// channel  | valid     | stall     | payload
// ---------+-----------+-----------+----------------------------------------------
// in       | in_valid  | in_stall  | pin_level
// out      | out_valid | out_stall | press_event press_kind mode_now series_now
//          |           |           | auto_now power_now
// cfg      | cfg_we    | -         | cfg_index cfg_data
//
// One item per cycle sustained while out_stall is low; each item passes the input register, then the result register.
// The item in the input register is classified and the state updated in the cycle
// it moves into the result register, so the next item sees the updated state.
// arst_n resets state and config registers to their defaults and clears both valid bits at once.
// in_stall rises only while the input register holds an item and the result
// register is full and stalled.

module button_press_length_mode_selector_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               pin_level,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    press_event,
	output logic [1:0]                              press_kind,
	output logic [bplms_pkg::CountW-1:0]            mode_now,
	output logic [bplms_pkg::CountW-1:0]            series_now,
	output logic                                    auto_now,
	output logic                                    power_now,
	input  wire logic                               cfg_we,
	input  wire logic [bplms_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [bplms_pkg::CfgW-1:0]         cfg_data
);

	logic [bplms_pkg::LimitW-1:0] short_limit_q;
	logic [bplms_pkg::LimitW-1:0] medium_limit_q;
	logic [bplms_pkg::LimitW-1:0] long_limit_q;
	logic [bplms_pkg::CountW-1:0] mode_count_q;
	logic [bplms_pkg::CountW-1:0] series_limit_q;

	logic [bplms_pkg::HoldW-1:0]  hold_q;
	logic                         was_pressed_q;
	logic [bplms_pkg::CountW-1:0] mode_q;
	logic [bplms_pkg::CountW-1:0] series_q;
	logic                         auto_q;
	logic                         power_q;

	logic                         valid_s1;
	logic                         pin_s1;

	logic                         out_valid_q;
	logic                         press_event_q;
	bplms_pkg::press_kind_t       press_kind_q;

	logic                         out_free;
	logic                         fire;
	logic                         pressed;
	logic                         classify;
	logic [bplms_pkg::HoldW-1:0]  hold_inc;
	bplms_pkg::press_kind_t       kind;
	logic [bplms_pkg::CountW:0]   mode_step;
	logic [bplms_pkg::CountW:0]   series_step;
	logic [bplms_pkg::HoldW-1:0]  hold_d;
	logic [bplms_pkg::CountW-1:0] mode_d;
	logic [bplms_pkg::CountW-1:0] series_d;
	logic                         auto_d;
	logic                         power_d;

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_limit_q  <= bplms_pkg::SHORT_LIMIT_RST;
			medium_limit_q <= bplms_pkg::MEDIUM_LIMIT_RST;
			long_limit_q   <= bplms_pkg::LONG_LIMIT_RST;
			mode_count_q   <= bplms_pkg::MODE_COUNT_RST;
			series_limit_q <= bplms_pkg::SERIES_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bplms_pkg::REG_SHORT_LIMIT:  short_limit_q  <= cfg_data;
				bplms_pkg::REG_MEDIUM_LIMIT: medium_limit_q <= cfg_data;
				bplms_pkg::REG_LONG_LIMIT:   long_limit_q   <= cfg_data;
				bplms_pkg::REG_MODE_COUNT:   mode_count_q   <= cfg_data[bplms_pkg::CountW-1:0];
				bplms_pkg::REG_SERIES_LIMIT: series_limit_q <= cfg_data[bplms_pkg::CountW-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			pin_s1 <= pin_level;
		end
	end

	// classify and next state
	always_comb begin
		pressed     = !pin_s1;
		hold_inc    = (pressed && hold_q != bplms_pkg::HOLD_MAX) ? hold_q + 16'd1 : hold_q;
		classify    = !pressed && !was_pressed_q;
		mode_step   = {1'b0, mode_q} + 5'd1;
		series_step = {1'b0, series_q} + 5'd1;
		kind        = bplms_pkg::KIND_NONE;
		hold_d      = hold_inc;
		mode_d      = mode_q;
		series_d    = series_q;
		auto_d      = auto_q;
		power_d     = power_q;
		if (classify) begin
			hold_d = '0;
			if (hold_inc > long_limit_q) begin
				kind    = bplms_pkg::KIND_LONG;
				power_d = !power_q;
			end else if (hold_inc > medium_limit_q) begin
				kind   = bplms_pkg::KIND_MEDIUM;
				mode_d = (mode_step > {1'b0, mode_count_q}) ? bplms_pkg::COUNT_ONE
				                                            : mode_step[bplms_pkg::CountW-1:0];
			end else if (hold_inc > short_limit_q) begin
				kind = bplms_pkg::KIND_SHORT;
				if (auto_q) begin
					auto_d   = 1'b0;
					series_d = bplms_pkg::COUNT_ONE;
				end else if (series_step >= {1'b0, series_limit_q}) begin
					auto_d   = 1'b1;
					series_d = bplms_pkg::COUNT_ONE;
				end else begin
					series_d = series_step[bplms_pkg::CountW-1:0];
				end
			end
		end
	end

	// state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q        <= '0;
			was_pressed_q <= 1'b0;
			mode_q        <= bplms_pkg::MODE_RST;
			series_q      <= bplms_pkg::SERIES_RST;
			auto_q        <= 1'b0;
			power_q       <= 1'b1;
		end else if (fire) begin
			hold_q        <= hold_d;
			was_pressed_q <= pressed;
			mode_q        <= mode_d;
			series_q      <= series_d;
			auto_q        <= auto_d;
			power_q       <= power_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			press_event_q <= (kind != bplms_pkg::KIND_NONE);
			press_kind_q  <= kind;
		end
	end

	// state registers double as the result's state fields
	assign out_valid   = out_valid_q;
	assign press_event = press_event_q;
	assign press_kind  = press_kind_q;
	assign mode_now    = mode_q;
	assign series_now  = series_q;
	assign auto_now    = auto_q;
	assign power_now   = power_q;

	a_mode_series_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (mode_q != '0 && series_q != '0))
		else $error("mode or series reached zero");

	a_hold_steps: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (hold_q == $past(hold_q) || hold_q == '0 ||
		          hold_q == $past(hold_q) + 16'd1))
		else $error("hold counter jumped");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a full stalled result");

	a_event_kind: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(power_q) || $fell(power_q) |-> $past(fire) && out_valid_q &&
		press_kind_q == bplms_pkg::KIND_LONG)
		else $error("power toggled without a long press");

endmodule

`default_nettype wire
